@@ design/ffba_pkg.sv @@
// Package for the first-fit block allocator.
// Holds the item types, the header entry type, status codes and default sizes.
// No dependencies.
package ffba_pkg;

    localparam int unsigned ARENA_BYTES_DEF  = 1024 * 64;
    localparam int unsigned HEADER_BYTES_DEF = 24;
    // Allocation granule; rounding relies on this being a power of two.
    localparam int unsigned ALIGN_BYTES      = 8;
    // Header bookkeeping is kept per 8-byte slot of the arena.
    localparam int unsigned SLOT_BYTES       = 8;
    localparam int unsigned SLOT_SHIFT       = $clog2(SLOT_BYTES);

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [16:0] request_bytes;
        logic [15:0] release_offset;
    } request_t;

    typedef struct packed {
        logic [15:0] user_offset;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [16:0] size;
        logic        free;
    } hdr_entry_t;

endpackage

@@ design/ffba_hdr_store.sv @@
// Header store of the first-fit block allocator: one entry per arena slot.
// Single write port, one registered read port; slot 0 reads as the reset
// block until it is first written. Depends on ffba_pkg.
module ffba_hdr_store
    import ffba_pkg::*;
#(
    parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
    localparam int unsigned DEPTH = ARENA_BYTES / SLOT_BYTES,
    localparam int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  hdr_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output hdr_entry_t    rd_data
);

    localparam logic [31:0] FIRST_SIZE = 32'(ARENA_BYTES - HEADER_BYTES);

    hdr_entry_t mem [DEPTH];
    hdr_entry_t mem_q;
    logic       first_written_reg;
    logic       first_written_next;
    logic       rd_first_reg;
    logic       rd_first_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_comb
    begin
        first_written_next = first_written_reg;
        if (wr_en && wr_addr == '0)
        begin
            first_written_next = 1'b1;
        end
        rd_first_next = rd_first_reg;
        if (rd_en)
        begin
            rd_first_next = (rd_addr == '0) && !first_written_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_written_reg <= 1'b0;
            rd_first_reg      <= 1'b0;
        end
        else
        begin
            first_written_reg <= first_written_next;
            rd_first_reg      <= rd_first_next;
        end
    end

    // Until slot 0 is written it holds the single free block of the whole arena.
    always_comb
    begin
        if (rd_first_reg)
        begin
            rd_data.size = FIRST_SIZE[16:0];
            rd_data.free = 1'b1;
        end
        else
        begin
            rd_data = mem_q;
        end
    end

endmodule

@@ design/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator.
// Instantiates ffba_hdr_store and depends on ffba_pkg.
//
// Usage: present a request item with start high; it is taken at a rising
// edge where start is high and busy is low. busy stays high while the item
// is worked on. Exactly one result item per request appears on result for
// one cycle, marked by done; the receiver must take it then, it cannot stall.
//
// Allocate walks the header chain from offset 0, one header memory read and
// one compare per visited block; on a fit a split step writes the header of
// a large remainder and a mark step the allocated one, and a next header
// beyond the arena ends in no fit. A zero-size request, or a free of offset 0,
// below one header, or beyond the arena, answers from idle with done in the
// next cycle. Free reads the header, then the next one for a merge when it
// lies within the arena, and writes the freed header. Memory reads bound the walk.
// A new item may be started in the cycle in which done is high.
//
// After reset the arena is a single free block; no clearing pass is needed.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    localparam int unsigned DEPTH = ARENA_BYTES / SLOT_BYTES;
    localparam int unsigned AW    = $clog2(DEPTH);
    // Wide enough for a header offset plus a header plus the largest size.
    localparam int unsigned OW    = $clog2(ARENA_BYTES + HEADER_BYTES + 131072);

    localparam logic [OW-1:0] ARENA_W  = OW'(ARENA_BYTES);
    localparam logic [OW-1:0] HEADER_W = OW'(HEADER_BYTES);
    localparam logic [17:0]   ALIGN_M  = ~18'(ALIGN_BYTES - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WALK_RD  = 4'd1;
    localparam logic [3:0] S_WALK_CHK = 4'd2;
    localparam logic [3:0] S_SPLIT    = 4'd3;
    localparam logic [3:0] S_MARK     = 4'd4;
    localparam logic [3:0] S_REL_RD   = 4'd5;
    localparam logic [3:0] S_REL_NXT  = 4'd6;
    localparam logic [3:0] S_REL_EX   = 4'd7;
    localparam logic [3:0] S_REL_MRG  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [OW-1:0] off_reg, off_next;
    logic [OW-1:0] nxt_reg, nxt_next;
    logic [17:0]   need_reg, need_next;
    logic [16:0]   size_reg, size_next;
    logic          split_reg, split_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    hdr_entry_t    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    hdr_entry_t    rd_data;

    // Shared offset adder: off_reg + header + operand.
    logic [17:0]   add_op;
    logic [OW-1:0] add_sum;
    // Shared end-of-chain check on a header offset.
    logic [OW-1:0] end_op;
    logic          hdr_fits;

    logic [17:0]   need_round;
    logic [16:0]   left;
    logic [OW-1:0] rel_hdr;

    ffba_hdr_store #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        unique case (state_reg)
            S_WALK_CHK, S_REL_NXT: add_op = {1'b0, rd_data.size};
            S_SPLIT:               add_op = need_reg;
            default:               add_op = '0;
        endcase
        add_sum  = off_reg + HEADER_W + OW'(add_op);
        end_op   = (state_reg == S_REL_EX) ? nxt_reg : off_reg;
        hdr_fits = (end_op + HEADER_W) <= ARENA_W;

        need_round = ({1'b0, request.request_bytes} + 18'(ALIGN_BYTES - 1)) & ALIGN_M;
        left       = size_reg - need_reg[16:0];
        rel_hdr    = OW'(request.release_offset) - HEADER_W;
    end

    always_comb
    begin
        state_next  = state_reg;
        off_next    = off_reg;
        nxt_next    = nxt_reg;
        need_next   = need_reg;
        size_next   = size_reg;
        split_next  = split_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = off_reg[AW+SLOT_SHIFT-1:SLOT_SHIFT];
        wr_data     = '{size: size_reg, free: 1'b1};
        rd_en       = 1'b0;
        rd_addr     = off_reg[AW+SLOT_SHIFT-1:SLOT_SHIFT];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.mode == MODE_ALLOC)
                    begin
                        if (request.request_bytes == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = '{user_offset: '0, status: ST_ZERO};
                        end
                        else
                        begin
                            need_next  = need_round;
                            off_next   = '0;
                            state_next = S_WALK_RD;
                        end
                    end
                    else
                    begin
                        // Null, below one header, or beyond the arena: nothing to do.
                        if (OW'(request.release_offset) < HEADER_W || rel_hdr >= ARENA_W)
                        begin
                            done_next   = 1'b1;
                            result_next = '{user_offset: '0, status: ST_DONE};
                        end
                        else
                        begin
                            off_next   = rel_hdr;
                            state_next = S_REL_RD;
                        end
                    end
                end
            end

            S_WALK_RD:
            begin
                if (!hdr_fits)
                begin
                    done_next   = 1'b1;
                    result_next = '{user_offset: '0, status: ST_NOFIT};
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_CHK:
            begin
                if (rd_data.free && {1'b0, rd_data.size} >= need_reg)
                begin
                    size_next  = rd_data.size;
                    state_next = S_SPLIT;
                end
                else
                begin
                    off_next   = add_sum;
                    state_next = S_WALK_RD;
                end
            end

            S_SPLIT:
            begin
                // The remainder becomes a new free block when it exceeds a header.
                split_next = left > 17'(HEADER_BYTES);
                if (left > 17'(HEADER_BYTES) && add_sum < ARENA_W)
                begin
                    wr_en   = 1'b1;
                    wr_addr = add_sum[AW+SLOT_SHIFT-1:SLOT_SHIFT];
                    wr_data = '{size: left - 17'(HEADER_BYTES), free: 1'b1};
                end
                state_next = S_MARK;
            end

            S_MARK:
            begin
                wr_en        = 1'b1;
                wr_data.size = split_reg ? need_reg[16:0] : size_reg;
                wr_data.free = 1'b0;
                done_next    = 1'b1;
                result_next  = '{user_offset: add_sum[15:0], status: ST_DONE};
                state_next   = S_IDLE;
            end

            S_REL_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_REL_NXT;
            end

            S_REL_NXT:
            begin
                size_next  = rd_data.size;
                nxt_next   = add_sum;
                state_next = S_REL_EX;
            end

            S_REL_EX:
            begin
                if (hdr_fits)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = nxt_reg[AW+SLOT_SHIFT-1:SLOT_SHIFT];
                    state_next = S_REL_MRG;
                end
                else
                begin
                    wr_en       = 1'b1;
                    done_next   = 1'b1;
                    result_next = '{user_offset: '0, status: ST_DONE};
                    state_next  = S_IDLE;
                end
            end

            S_REL_MRG:
            begin
                // Forward merge only; the merged size wraps to the field width.
                wr_en = 1'b1;
                if (rd_data.free)
                begin
                    wr_data.size = size_reg + 17'(HEADER_BYTES) + rd_data.size;
                end
                done_next   = 1'b1;
                result_next = '{user_offset: '0, status: ST_DONE};
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        nxt_reg    <= nxt_next;
        need_reg   <= need_next;
        size_reg   <= size_next;
        split_reg  <= split_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
